### rtl/hrpa_pkg.sv
// hrpa_pkg: shared constants, command codes and hex decode for the hex record page assembler
// no dependencies
`timescale 1ns / 1ps

package hrpa_pkg;

  localparam int PAGE_BYTES_DEF  = 128;
  localparam int CARRY_BYTES_DEF = 32;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int OFS_W  = 7;
  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHAR = 2'd0,
    CMD_READ = 2'd1,
    CMD_TAKE = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  localparam logic [BYTE_W-1:0] REC_DATA = 8'h00;
  localparam logic [BYTE_W-1:0] REC_EOF  = 8'h01;
  localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;

  localparam logic [ADDR_W-1:0] ADDR_STEP = 16'h0080;

  localparam logic [POS_W-1:0] POS_COUNT_HI = 10'd1;
  localparam logic [POS_W-1:0] POS_COUNT_LO = 10'd2;
  localparam logic [POS_W-1:0] POS_TYPE_HI  = 10'd7;
  localparam logic [POS_W-1:0] POS_TYPE_LO  = 10'd8;
  localparam logic [POS_W-1:0] POS_DATA     = 10'd9;
  localparam logic [POS_W-1:0] POS_MAX      = 10'd1023;

  // non-hex characters decode as zero
  function automatic logic [3:0] hex_digit(input logic [CHAR_W-1:0] c);
    logic [3:0] d;
    d = 4'd0;
    if (c inside {[8'h30:8'h39]}) begin
      d = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      d = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

### rtl/hex_record_page_assembler.sv
// hex_record_page_assembler: top level, record character sequencer around page and carry rams
// depends on hrpa_pkg and hrpa_ram
`timescale 1ns / 1ps

// Takes hex record text one character per item and builds flash pages in a
// page ram of PAGE_BYTES bytes; bytes past a full page wait in a carry ram of
// CARRY_BYTES bytes. Every item gives exactly one result: the ready flag and
// page address after the item, the read byte for a read command, and a flag
// for lost data bytes. Record characters, take-address and no-op commands
// complete in the cycle they are accepted. A page read gives its result from
// S_READ, after the registered page ram read. A record start with carried
// bytes pending first copies each by a carry ram read in S_COPY_RD and
// a page ram write in S_COPY_WR. An end-of-file record pads the page at one
// byte per cycle in S_PAD. The block takes the next item only in a cycle
// where the output register is empty or its result is taken, so a stalled
// result holds the input. No clearing pass after reset: the carry ram is filled
// before it is read; the user must read only filled page bytes (unenforced).
module hex_record_page_assembler #(
  parameter int PAGE_BYTES  = hrpa_pkg::PAGE_BYTES_DEF,
  parameter int CARRY_BYTES = hrpa_pkg::CARRY_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hrpa_pkg::CMD_W-1:0]    in_command,
  input  logic [hrpa_pkg::CHAR_W-1:0]   in_character,
  input  logic                          in_record_start,
  input  logic [hrpa_pkg::OFS_W-1:0]    in_read_offset,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_ready_res,
  output logic [hrpa_pkg::ADDR_W-1:0]   out_page_address,
  output logic [hrpa_pkg::BYTE_W-1:0]   out_read_data,
  output logic                          out_dropped
);

  localparam int PAGE_AW  = $clog2(PAGE_BYTES);
  localparam int CARRY_AW = $clog2(CARRY_BYTES);
  localparam int FILL_W   = $clog2(PAGE_BYTES + 1);
  localparam int CNT_W    = $clog2(CARRY_BYTES + 1);
  localparam int OFS_X_W  = PAGE_AW + hrpa_pkg::OFS_W;
  localparam int BW       = hrpa_pkg::BYTE_W;
  localparam int PW       = hrpa_pkg::POS_W;

  localparam logic [FILL_W-1:0]  PAGE_FULL  = FILL_W'(PAGE_BYTES);
  localparam logic [CNT_W-1:0]   CARRY_FULL = CNT_W'(CARRY_BYTES);
  localparam logic [OFS_X_W-1:0] PAGE_LIM   = OFS_X_W'(PAGE_BYTES);
  localparam logic [BW-1:0]      PAD_BYTE_L = hrpa_pkg::PAD_BYTE;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_READ    = 5'b00010,
    S_COPY_RD = 5'b00100,
    S_COPY_WR = 5'b01000,
    S_PAD     = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [FILL_W-1:0]           fill_r, fill_nxt;
  logic [CNT_W-1:0]            carry_cnt_r, carry_cnt_nxt;
  logic                        carry_pend_r, carry_pend_nxt;
  logic [hrpa_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic                        first_r, first_nxt;
  logic                        ready_r, ready_nxt;
  logic [PW-1:0]               pos_r, pos_nxt;
  logic [BW-1:0]               kind_r, kind_nxt;
  logic [BW-1:0]               count_r, count_nxt;
  logic [3:0]                  nib_r, nib_nxt;
  logic [CNT_W-1:0]            copy_idx_r, copy_idx_nxt;
  logic                        lost_r, lost_nxt;
  logic                        rd_ok_r, rd_ok_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_rdy_r;
  logic [hrpa_pkg::ADDR_W-1:0] out_addr_r;
  logic [BW-1:0]               out_data_r;
  logic                        out_drop_r;

  logic                        page_we;
  logic [PAGE_AW-1:0]          page_waddr, page_raddr;
  logic [BW-1:0]               page_wdata, page_rdata;
  logic                        carry_we;
  logic [CARRY_AW-1:0]         carry_waddr, carry_raddr;
  logic [BW-1:0]               carry_wdata, carry_rdata;

  logic                        in_acc;
  logic                        done;
  logic [BW-1:0]               res_data;
  logic                        res_drop;
  logic                        rec_done;
  logic [FILL_W-1:0]           chk_fill;
  logic [CNT_W-1:0]            chk_cnt;
  logic [3:0]                  digit;
  logic [BW-1:0]               byte_val;
  logic [PW-1:0]               end_pos;
  logic [OFS_X_W-1:0]          ofs_ext;
  logic                        to_page, to_carry;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;
  assign digit    = hrpa_pkg::hex_digit(in_character);
  assign byte_val = {nib_r, digit};
  assign end_pos  = hrpa_pkg::POS_TYPE_LO + PW'({count_r, 1'b0});
  assign ofs_ext  = OFS_X_W'(in_read_offset);
  assign to_page  = fill_r < PAGE_FULL;
  assign to_carry = !to_page && (carry_cnt_r < CARRY_FULL);

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    carry_cnt_nxt  = carry_cnt_r;
    carry_pend_nxt = carry_pend_r;
    addr_nxt       = addr_r;
    first_nxt      = first_r;
    ready_nxt      = ready_r;
    pos_nxt        = pos_r;
    kind_nxt       = kind_r;
    count_nxt      = count_r;
    nib_nxt        = nib_r;
    copy_idx_nxt   = copy_idx_r;
    lost_nxt       = lost_r;
    rd_ok_nxt      = rd_ok_r;
    page_we        = 1'b0;
    page_waddr     = fill_r[PAGE_AW-1:0];
    page_wdata     = PAD_BYTE_L;
    page_raddr     = ofs_ext[PAGE_AW-1:0];
    carry_we       = 1'b0;
    carry_waddr    = carry_cnt_r[CARRY_AW-1:0];
    carry_wdata    = byte_val;
    carry_raddr    = copy_idx_r[CARRY_AW-1:0];
    done           = 1'b0;
    res_data       = '0;
    res_drop       = 1'b0;
    rec_done       = 1'b0;
    chk_fill       = fill_r;
    chk_cnt        = carry_cnt_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_command)
            hrpa_pkg::CMD_CHAR: begin
              if (in_record_start) begin
                kind_nxt  = '0;
                count_nxt = '0;
                pos_nxt   = hrpa_pkg::POS_COUNT_HI;
                if (carry_pend_r && (carry_cnt_r != '0)) begin
                  copy_idx_nxt = '0;
                  lost_nxt     = 1'b0;
                  state_nxt    = S_COPY_RD;
                end else begin
                  if (carry_pend_r) begin
                    carry_cnt_nxt  = '0;
                    carry_pend_nxt = 1'b0;
                  end
                  done = 1'b1;
                end
              end else begin
                done    = 1'b1;
                pos_nxt = (pos_r == hrpa_pkg::POS_MAX) ? pos_r : pos_r + PW'(1);
                if (pos_r == hrpa_pkg::POS_COUNT_HI || pos_r == hrpa_pkg::POS_TYPE_HI) begin
                  nib_nxt = digit;
                end else if (pos_r == hrpa_pkg::POS_COUNT_LO) begin
                  count_nxt = byte_val;
                end else if (pos_r == hrpa_pkg::POS_TYPE_LO) begin
                  kind_nxt = byte_val;
                  if (byte_val == hrpa_pkg::REC_DATA && count_r == '0) begin
                    rec_done = 1'b1;
                  end else if (byte_val == hrpa_pkg::REC_EOF) begin
                    addr_nxt  = addr_r + hrpa_pkg::ADDR_STEP;
                    ready_nxt = 1'b1;
                    if (to_page) begin
                      done      = 1'b0;
                      state_nxt = S_PAD;
                    end
                  end
                end else if (pos_r >= hrpa_pkg::POS_DATA && kind_r == hrpa_pkg::REC_DATA &&
                             pos_r <= end_pos) begin
                  if (pos_r[0]) begin
                    nib_nxt = digit;
                  end else begin
                    if (to_page) begin
                      page_we    = 1'b1;
                      page_wdata = byte_val;
                      fill_nxt   = fill_r + FILL_W'(1);
                      chk_fill   = fill_r + FILL_W'(1);
                    end else if (to_carry) begin
                      carry_we      = 1'b1;
                      carry_cnt_nxt = carry_cnt_r + CNT_W'(1);
                      chk_cnt       = carry_cnt_r + CNT_W'(1);
                    end else begin
                      res_drop = 1'b1;
                    end
                    rec_done = (pos_r == end_pos);
                  end
                end
              end
            end
            hrpa_pkg::CMD_READ: begin
              rd_ok_nxt = ofs_ext < PAGE_LIM;
              state_nxt = S_READ;
            end
            hrpa_pkg::CMD_TAKE: begin
              ready_nxt = 1'b0;
              done      = 1'b1;
            end
            default: begin
              done = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        done      = 1'b1;
        res_data  = rd_ok_r ? page_rdata : '0;
        state_nxt = S_IDLE;
      end
      S_COPY_RD: begin
        state_nxt = S_COPY_WR;
      end
      S_COPY_WR: begin
        if (to_page) begin
          page_we    = 1'b1;
          page_wdata = carry_rdata;
          fill_nxt   = fill_r + FILL_W'(1);
        end else begin
          lost_nxt = 1'b1;
        end
        if (copy_idx_r + CNT_W'(1) == carry_cnt_r) begin
          carry_cnt_nxt  = '0;
          carry_pend_nxt = 1'b0;
          done           = 1'b1;
          res_drop       = lost_r || !to_page;
          state_nxt      = S_IDLE;
        end else begin
          copy_idx_nxt = copy_idx_r + CNT_W'(1);
          state_nxt    = S_COPY_RD;
        end
      end
      S_PAD: begin
        page_we  = 1'b1;
        fill_nxt = fill_r + FILL_W'(1);
        if (fill_r + FILL_W'(1) == PAGE_FULL) begin
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // page completion at the end of a data record
    if (rec_done && chk_fill >= PAGE_FULL) begin
      if (chk_cnt != '0) begin
        carry_pend_nxt = 1'b1;
      end
      if (!first_r) begin
        addr_nxt = addr_r + hrpa_pkg::ADDR_STEP;
      end
      fill_nxt  = '0;
      first_nxt = 1'b0;
      ready_nxt = 1'b1;
    end

    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      carry_cnt_r  <= '0;
      carry_pend_r <= 1'b0;
      addr_r       <= '0;
      first_r      <= 1'b1;
      ready_r      <= 1'b0;
      pos_r        <= '0;
      kind_r       <= '0;
      count_r      <= '0;
      nib_r        <= '0;
      copy_idx_r   <= '0;
      lost_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      carry_cnt_r  <= carry_cnt_nxt;
      carry_pend_r <= carry_pend_nxt;
      addr_r       <= addr_nxt;
      first_r      <= first_nxt;
      ready_r      <= ready_nxt;
      pos_r        <= pos_nxt;
      kind_r       <= kind_nxt;
      count_r      <= count_nxt;
      nib_r        <= nib_nxt;
      copy_idx_r   <= copy_idx_nxt;
      lost_r       <= lost_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ok_r <= rd_ok_nxt;
    if (done) begin
      out_rdy_r  <= ready_nxt;
      out_addr_r <= addr_nxt;
      out_data_r <= res_data;
      out_drop_r <= res_drop;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_ready_res    = out_rdy_r;
  assign out_page_address = out_addr_r;
  assign out_read_data    = out_data_r;
  assign out_dropped      = out_drop_r;

  hrpa_ram #(
    .WIDTH(BW),
    .DEPTH(PAGE_BYTES)
  ) u_page_ram (
    .clk  (clk),
    .we   (page_we),
    .waddr(page_waddr),
    .wdata(page_wdata),
    .raddr(page_raddr),
    .rdata(page_rdata)
  );

  hrpa_ram #(
    .WIDTH(BW),
    .DEPTH(CARRY_BYTES)
  ) u_carry_ram (
    .clk  (clk),
    .we   (carry_we),
    .waddr(carry_waddr),
    .wdata(carry_wdata),
    .raddr(carry_raddr),
    .rdata(carry_rdata)
  );

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= PAGE_FULL)
    else $error("page fill level past page size");

  a_pend_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    carry_pend_r |-> (carry_cnt_r != '0))
    else $error("carry copy pending with empty carry store");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("item accepted while previous item still in progress");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> out_valid_r)
    else $error("page read finished without a result");

endmodule

### rtl/hrpa_ram.sv
// hrpa_ram: generic simple dual-port ram, one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps

module hrpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### verif/hex_record_page_assembler_tb.sv
// hex_record_page_assembler_tb: self-checking testbench for the hex record page assembler
// drives record text and page commands, predicts each result item and checks it in order
// depends on hrpa_pkg and hex_record_page_assembler
`timescale 1ns / 1ps

module hex_record_page_assembler_tb;

  localparam int PAGE_BYTES  = hrpa_pkg::PAGE_BYTES_DEF;
  localparam int CARRY_BYTES = hrpa_pkg::CARRY_BYTES_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 300;
  localparam int RANDOM_ITEMS = 300;

  typedef struct packed {
    logic                        ready_res;
    logic [hrpa_pkg::ADDR_W-1:0] page_address;
    logic [hrpa_pkg::BYTE_W-1:0] read_data;
    logic                        dropped;
  } page_result_t;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_NONHEX} fill_mode_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [hrpa_pkg::CMD_W-1:0]  in_command = hrpa_pkg::CMD_NONE;
  logic [hrpa_pkg::CHAR_W-1:0] in_character = '0;
  logic                        in_record_start = 1'b0;
  logic [hrpa_pkg::OFS_W-1:0]  in_read_offset = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic                        out_ready_res;
  logic [hrpa_pkg::ADDR_W-1:0] out_page_address;
  logic [hrpa_pkg::BYTE_W-1:0] out_read_data;
  logic                        out_dropped;

  hex_record_page_assembler #(
    .PAGE_BYTES (PAGE_BYTES),
    .CARRY_BYTES(CARRY_BYTES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_character    (in_character),
    .in_record_start (in_record_start),
    .in_read_offset  (in_read_offset),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ready_res   (out_ready_res),
    .out_page_address(out_page_address),
    .out_read_data   (out_read_data),
    .out_dropped     (out_dropped)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted block state
  logic [hrpa_pkg::BYTE_W-1:0] page_img [PAGE_BYTES];
  bit                          page_written [PAGE_BYTES];
  logic [hrpa_pkg::BYTE_W-1:0] carry_img [CARRY_BYTES];
  int                          fill_lvl = 0;
  int                          carry_cnt = 0;
  bit                          carry_pend = 1'b0;
  logic [hrpa_pkg::ADDR_W-1:0] flash_addr = '0;
  bit                          first_pg = 1'b1;
  bit                          pg_ready = 1'b0;
  int                          char_pos = 0;
  logic [hrpa_pkg::BYTE_W-1:0] rec_kind = '0;
  int                          rec_count = 0;
  logic [3:0]                  hi_nib = '0;

  page_result_t pending_results [$];
  int           fail_count = 0;
  int           items_sent = 0;
  int           burst_left = 0;
  int           idle_cycles = 0;
  int           rx_cycle = 0;
  int           rx_mode = 0;

  function automatic logic [3:0] nibble_of(logic [hrpa_pkg::CHAR_W-1:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
    return 4'd0;
  endfunction

  function automatic logic [hrpa_pkg::CHAR_W-1:0] hex_char(logic [3:0] n, bit lower);
    if (n < 10) return 8'h30 + 8'(n);
    return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic void close_data_record();
    if (fill_lvl >= PAGE_BYTES) begin
      if (carry_cnt > 0) carry_pend = 1'b1;
      if (!first_pg) flash_addr = flash_addr + hrpa_pkg::ADDR_STEP;
      fill_lvl = 0;
      first_pg = 1'b0;
      pg_ready = 1'b1;
    end
  endfunction

  function automatic page_result_t assemble_step(hrpa_pkg::cmd_t cmd,
                                                 logic [hrpa_pkg::CHAR_W-1:0] ch, logic st,
                                                 logic [hrpa_pkg::OFS_W-1:0] ofs);
    page_result_t r;
    int pos;
    logic [3:0] d;
    logic [hrpa_pkg::BYTE_W-1:0] b;
    bit lost;
    lost = 1'b0;
    r.read_data = '0;
    case (cmd)
      hrpa_pkg::CMD_CHAR: begin
        d = nibble_of(ch);
        if (st) begin
          if (carry_pend) begin
            for (int i = 0; i < carry_cnt; i++) begin
              if (fill_lvl < PAGE_BYTES) begin
                page_img[fill_lvl] = carry_img[i];
                page_written[fill_lvl] = 1'b1;
                fill_lvl++;
              end else begin
                lost = 1'b1;
              end
            end
            carry_cnt = 0;
            carry_pend = 1'b0;
          end
          pos = 0;
          rec_kind = '0;
          rec_count = 0;
        end else begin
          pos = char_pos;
        end
        if (pos == hrpa_pkg::POS_COUNT_HI || pos == hrpa_pkg::POS_TYPE_HI) begin
          hi_nib = d;
        end else if (pos == hrpa_pkg::POS_COUNT_LO) begin
          rec_count = int'({hi_nib, d});
        end else if (pos == hrpa_pkg::POS_TYPE_LO) begin
          rec_kind = {hi_nib, d};
          if (rec_kind == hrpa_pkg::REC_DATA && rec_count == 0) begin
            close_data_record();
          end else if (rec_kind == hrpa_pkg::REC_EOF) begin
            flash_addr = flash_addr + hrpa_pkg::ADDR_STEP;
            while (fill_lvl < PAGE_BYTES) begin
              page_img[fill_lvl] = hrpa_pkg::PAD_BYTE;
              page_written[fill_lvl] = 1'b1;
              fill_lvl++;
            end
            pg_ready = 1'b1;
          end
        end else if (pos >= hrpa_pkg::POS_DATA && rec_kind == hrpa_pkg::REC_DATA &&
                     pos <= hrpa_pkg::POS_TYPE_LO + 2 * rec_count) begin
          if (pos % 2 == 1) begin
            hi_nib = d;
          end else begin
            b = {hi_nib, d};
            if (fill_lvl < PAGE_BYTES) begin
              page_img[fill_lvl] = b;
              page_written[fill_lvl] = 1'b1;
              fill_lvl++;
            end else if (carry_cnt < CARRY_BYTES) begin
              carry_img[carry_cnt] = b;
              carry_cnt++;
            end else begin
              lost = 1'b1;
            end
            if (pos == hrpa_pkg::POS_TYPE_LO + 2 * rec_count) close_data_record();
          end
        end
        char_pos = (pos < hrpa_pkg::POS_MAX) ? pos + 1 : hrpa_pkg::POS_MAX;
      end
      hrpa_pkg::CMD_READ: r.read_data = page_img[ofs];
      hrpa_pkg::CMD_TAKE: pg_ready = 1'b0;
      default: ;
    endcase
    r.ready_res = pg_ready;
    r.page_address = flash_addr;
    r.dropped = lost;
    return r;
  endfunction

  task automatic send_item(hrpa_pkg::cmd_t cmd, logic [hrpa_pkg::CHAR_W-1:0] ch, logic st,
                           logic [hrpa_pkg::OFS_W-1:0] ofs);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_command <= cmd;
    in_character <= ch;
    in_record_start <= st;
    in_read_offset <= ofs;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(assemble_step(cmd, ch, st, ofs));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // reads only touch page bytes that have been written
  task automatic send_control();
    int sel;
    int ofs;
    int start_ofs;
    sel = $urandom_range(0, 9);
    ofs = -1;
    start_ofs = $urandom_range(0, PAGE_BYTES - 1);
    for (int k = 0; k < PAGE_BYTES && ofs < 0; k++) begin
      if (page_written[(start_ofs + k) % PAGE_BYTES]) ofs = (start_ofs + k) % PAGE_BYTES;
    end
    if (sel < 6 && ofs >= 0) begin
      send_item(hrpa_pkg::CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                7'(ofs));
    end else if (sel < 9) begin
      send_item(hrpa_pkg::CMD_TAKE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                7'($urandom_range(0, 127)));
    end else begin
      send_item(hrpa_pkg::CMD_NONE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                7'($urandom_range(0, 127)));
    end
  endtask

  task automatic send_read(int ofs);
    send_item(hrpa_pkg::CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              7'(ofs));
  endtask

  task automatic send_record(logic [hrpa_pkg::BYTE_W-1:0] kind, int count, fill_mode_t fill,
                             int cut_at, bit mix_ctrl);
    logic [hrpa_pkg::CHAR_W-1:0] chars [$];
    logic [hrpa_pkg::BYTE_W-1:0] b;
    logic [hrpa_pkg::CHAR_W-1:0] c;
    bit lower;
    lower = 1'($urandom_range(0, 1));
    chars.push_back(8'h3A);
    chars.push_back(hex_char(count[7:4], lower));
    chars.push_back(hex_char(count[3:0], lower));
    repeat (4) chars.push_back(hex_char(4'($urandom_range(0, 15)), lower));
    chars.push_back(hex_char(kind[7:4], lower));
    chars.push_back(hex_char(kind[3:0], lower));
    repeat (count) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(0, 255));
      endcase
      for (int h = 0; h < 2; h++) begin
        c = hex_char(h == 0 ? b[7:4] : b[3:0], lower);
        if (fill == FILL_NONHEX && $urandom_range(0, 2) == 0) begin
          do c = 8'($urandom_range(0, 255));
          while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
                 (c >= 8'h61 && c <= 8'h66));
        end
        chars.push_back(c);
      end
    end
    repeat (2) chars.push_back(hex_char(4'($urandom_range(0, 15)), lower));
    if ($urandom_range(0, 1)) begin
      chars.push_back(8'h0D);
      chars.push_back(8'h0A);
    end
    foreach (chars[i]) begin
      if (cut_at >= 0 && i >= cut_at) break;
      if (mix_ctrl && $urandom_range(0, 7) == 0) send_control();
      send_item(hrpa_pkg::CMD_CHAR, chars[i], i == 0, 7'($urandom_range(0, 127)));
    end
  endtask

  task automatic send_noise(int n, bit allow_start);
    repeat (n) begin
      send_item(hrpa_pkg::CMD_CHAR, 8'($urandom_range(0, 255)),
                allow_start && $urandom_range(0, 7) == 0, 7'($urandom_range(0, 127)));
    end
  endtask

  task automatic test_idle_commands();
    send_item(hrpa_pkg::CMD_TAKE, 8'h00, 1'b0, 7'h00);
    send_item(hrpa_pkg::CMD_NONE, 8'hFF, 1'b1, 7'h7F);
  endtask

  task automatic test_full_page();
    send_record(hrpa_pkg::REC_DATA, 16, FILL_ZERO, -1, 1'b0);
    send_record(hrpa_pkg::REC_DATA, 16, FILL_ONES, -1, 1'b0);
    repeat (6) send_record(hrpa_pkg::REC_DATA, 16, FILL_RANDOM, -1, 1'b0);
    send_read(0);
    send_read(PAGE_BYTES - 1);
    send_item(hrpa_pkg::CMD_TAKE, 8'h00, 1'b0, 7'h00);
  endtask

  // page overflow into the carry store, then carry full drops
  task automatic test_carry_and_drop();
    send_record(hrpa_pkg::REC_DATA, 112, FILL_RANDOM, -1, 1'b0);
    send_record(hrpa_pkg::REC_DATA, 60, FILL_RANDOM, -1, 1'b0);
    send_record(hrpa_pkg::REC_DATA, 4, FILL_RANDOM, -1, 1'b0);
    send_read(0);
    send_read(35);
  endtask

  task automatic test_end_of_file();
    send_record(hrpa_pkg::REC_EOF, 0, FILL_RANDOM, -1, 1'b0);
    send_read(PAGE_BYTES - 1);
    send_item(hrpa_pkg::CMD_TAKE, 8'h00, 1'b0, 7'h00);
    send_record(hrpa_pkg::REC_DATA, 0, FILL_RANDOM, -1, 1'b0);
    send_record(hrpa_pkg::REC_DATA, 0, FILL_RANDOM, -1, 1'b0);
    send_record(hrpa_pkg::REC_EOF, 2, FILL_RANDOM, -1, 1'b0);
    send_record(hrpa_pkg::REC_DATA, 20, FILL_RANDOM, -1, 1'b0);
  endtask

  task automatic test_odd_records();
    send_record(hrpa_pkg::REC_DATA, 10, FILL_RANDOM, 15, 1'b0);
    send_record(hrpa_pkg::REC_DATA, 8, FILL_NONHEX, -1, 1'b0);
    send_record(8'h05, 6, FILL_RANDOM, -1, 1'b0);
    send_noise(5, 1'b1);
    send_read(10);
  endtask

  // position counter saturation on an overlong line
  task automatic test_long_line();
    send_record(8'h04, 2, FILL_RANDOM, -1, 1'b0);
    send_noise(1040, 1'b0);
    send_record(hrpa_pkg::REC_DATA, 3, FILL_RANDOM, -1, 1'b0);
  endtask

  task automatic test_random();
    int stop_at;
    int next_pause;
    int sel;
    int count;
    stop_at = items_sent + RANDOM_ITEMS;
    next_pause = items_sent + $urandom_range(200, 500);
    while (items_sent < stop_at) begin
      sel = $urandom_range(0, 99);
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 24);
      if (sel < 70) begin
        send_record(hrpa_pkg::REC_DATA, count, fill_mode_t'($urandom_range(0, 3)), -1, 1'b1);
      end else if (sel < 75) begin
        send_record(hrpa_pkg::REC_EOF, $urandom_range(0, 4), FILL_RANDOM, -1, 1'b1);
      end else if (sel < 79) begin
        send_record(8'($urandom_range(2, 255)), $urandom_range(0, 8), FILL_RANDOM, -1, 1'b1);
      end else if (sel < 85) begin
        count = $urandom_range(1, 40);
        send_record(hrpa_pkg::REC_DATA, count, FILL_RANDOM, $urandom_range(1, 11 + 2 * count),
                    1'b1);
      end else if (sel < 92) begin
        repeat ($urandom_range(1, 4)) send_control();
      end else begin
        send_noise($urandom_range(1, 6), 1'b1);
      end
      if (items_sent >= next_pause) begin
        wait_drained();
        next_pause = items_sent + $urandom_range(200, 500);
      end
    end
  endtask

  // receiver stall pattern, switching among four randomly chosen modes
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 256 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_cycle % 4 == 0);
      default: out_ready <= (rx_cycle % 32 >= 20);
    endcase
  end

  always @(posedge clk) begin : check_results
    page_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        if (fail_count < 10) begin
          $display("unexpected item: ready_res=%0d page_address=%h read_data=%h dropped=%0d",
                   out_ready_res, out_page_address, out_read_data, out_dropped);
        end
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ready_res !== exp_r.ready_res || out_page_address !== exp_r.page_address ||
            out_read_data !== exp_r.read_data || out_dropped !== exp_r.dropped) begin
          if (fail_count < 10) begin
            $display("mismatch: ready_res %0d/%0d page_address %h/%h ",
                     "read_data %h/%h dropped %0d/%0d",
                     exp_r.ready_res, out_ready_res, exp_r.page_address, out_page_address,
                     exp_r.read_data, out_read_data, exp_r.dropped, out_dropped);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_idle_commands();
    test_full_page();
    test_carry_and_drop();
    test_end_of_file();
    test_odd_records();
    wait_drained();
    test_long_line();
    test_random();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
